// File: rtl/core/ubfh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubfh_pkg: shared types and constants
// Beat payloads, command codes and error codes of the flash host.
// ----------------------------------------------------------------------------
package ubfh_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_IMAGE = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_SYNC    = 3'd1;
  localparam logic [2:0] ERR_TIMEOUT = 3'd2;
  localparam logic [2:0] ERR_NACK    = 3'd3;
  localparam logic [2:0] ERR_UNEXP   = 3'd4;
  localparam logic [2:0] ERR_BADLEN  = 3'd5;
  localparam logic [2:0] ERR_ORDER   = 3'd6;

  localparam logic [7:0] BL_ACK      = 8'h79;
  localparam logic [7:0] BL_NACK     = 8'h1F;
  localparam logic [7:0] CMD_SYNC    = 8'h7F;
  localparam logic [7:0] CMD_READ_ID = 8'h02;
  localparam logic [7:0] CMD_ERASE   = 8'h44;
  localparam logic [7:0] CMD_WRITE   = 8'h31;
  localparam logic [13:0] SYNC_PAUSE = 14'd50;

  localparam logic [2:0] REG_START_ADDR = 3'd0;
  localparam logic [2:0] REG_IMAGE_LEN  = 3'd1;
  localparam logic [2:0] REG_SYNC_LIM   = 3'd2;
  localparam logic [2:0] REG_SYNC_TO    = 3'd3;
  localparam logic [2:0] REG_CMD_TO     = 3'd4;
  localparam logic [2:0] REG_ERASE_TO   = 3'd5;
  localparam logic [2:0] REG_WRITE_TO   = 3'd6;
  localparam logic [2:0] REG_CHIP_ID    = 3'd7;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] image_byte;
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  error_code;
    logic [15:0] chip_id;
    logic        chip_mismatch;
    logic [24:0] bytes_written;
    logic        want_image_byte;
  } out_beat_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [2:0]  err;
    logic [15:0] chip_id;
    logic        mismatch;
    logic [24:0] offset;
    logic        want;
  } status_t;

  // One step's work: up to five bytes plus the status after the step.
  typedef struct packed {
    logic [2:0]      ntx;
    logic [4:0][7:0] txb;
    status_t         st;
  } step_t;

endpackage

// File: rtl/core/ubfh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubfh_front: protocol sequencer
// Accepts one input beat per cycle, advances the flashing exchange and
// emits one step record (bytes to send plus status) into the queue.
// ----------------------------------------------------------------------------
module ubfh_front #(
  parameter int MAX_CHUNK = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  input  logic                beat_valid,
  input  ubfh_pkg::in_beat_t  beat,
  output logic                step_valid,
  output ubfh_pkg::step_t     step
);

  localparam int CW = $clog2(MAX_CHUNK + 1);
  localparam logic [24:0] MAXC25 = 25'(MAX_CHUNK);

  typedef enum logic [3:0] {
    PH_IDLE, PH_SYNC_WAIT, PH_SYNC_PAUSE, PH_ID_CMD_ACK, PH_ID_COUNT,
    PH_ID_BYTES, PH_ID_ACK, PH_ERASE_CMD_ACK, PH_ERASE_ACK,
    PH_WR_CMD_ACK, PH_WR_ADDR_ACK, PH_WR_DATA, PH_WR_ACK
  } phase_t;

  logic [31:0] start_address_r;
  logic [24:0] image_length_r;
  logic [13:0] sync_lim_r, sync_to_r, cmd_to_r, erase_to_r, write_to_r;
  logic [15:0] exp_id_r;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  id_idx_r, id_idx_nxt;
  logic [CW-1:0] byte_idx_r, byte_idx_nxt, chunk_r, chunk_nxt;
  logic [13:0] wait_r, wait_nxt, retry_r, retry_nxt;
  logic [7:0]  csum_r, csum_nxt;
  logic [24:0] offset_r, offset_nxt, run_len_r, run_len_nxt;
  logic [31:0] run_addr_r, run_addr_nxt;
  logic [15:0] id_r, id_nxt, chip_r, chip_nxt;
  logic [8:0]  id_left_r, id_left_nxt;
  logic        done_r, done_nxt, mism_r, mism_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        sv_r;
  ubfh_pkg::step_t step_r;

  logic [2:0]      ntx;
  logic [4:0][7:0] txb;
  logic [31:0]     addr;
  logic [24:0]     rem, off_sum;
  logic [CW-1:0]   csz;
  logic [13:0]     retry_inc;

  always_comb begin
    phase_nxt = phase_r;   id_idx_nxt = id_idx_r;  byte_idx_nxt = byte_idx_r;
    chunk_nxt = chunk_r;   wait_nxt = wait_r;      retry_nxt = retry_r;
    csum_nxt = csum_r;     offset_nxt = offset_r;  run_len_nxt = run_len_r;
    run_addr_nxt = run_addr_r; id_nxt = id_r;      chip_nxt = chip_r;
    id_left_nxt = id_left_r;   done_nxt = done_r;  mism_nxt = mism_r;
    err_nxt = err_r;
    ntx = 3'd0;
    txb = '0;
    addr = run_addr_r + {7'd0, offset_r};
    rem = run_len_r - offset_r;
    csz = (rem > MAXC25) ? CW'(MAX_CHUNK) : rem[CW-1:0];
    off_sum = offset_r + 25'(chunk_r);
    retry_inc = retry_r + 14'd1;
    unique case (beat.op)
      ubfh_pkg::OP_START: begin
        if (phase_r == PH_IDLE) begin
          done_nxt = 1'b0; mism_nxt = 1'b0; chip_nxt = '0; id_nxt = '0;
          offset_nxt = '0; retry_nxt = '0;
          if (image_length_r == '0) begin
            err_nxt = ubfh_pkg::ERR_BADLEN;
          end else begin
            err_nxt = ubfh_pkg::ERR_NONE;
            run_addr_nxt = start_address_r;
            run_len_nxt = image_length_r;
            txb[0] = ubfh_pkg::CMD_SYNC; ntx = 3'd1;
            wait_nxt = sync_to_r;
            phase_nxt = PH_SYNC_WAIT;
          end
        end
      end
      ubfh_pkg::OP_IMAGE: begin
        if (phase_r != PH_WR_DATA) begin
          err_nxt = ubfh_pkg::ERR_ORDER; phase_nxt = PH_IDLE;
        end else begin
          txb[0] = beat.image_byte; ntx = 3'd1;
          csum_nxt = csum_r ^ beat.image_byte;
          byte_idx_nxt = byte_idx_r + 1'b1;
          if (byte_idx_nxt >= chunk_r) begin
            txb[1] = csum_nxt; ntx = 3'd2;
            wait_nxt = write_to_r;
            phase_nxt = PH_WR_ACK;
          end
        end
      end
      ubfh_pkg::OP_RX: begin
        priority case (phase_r)
          PH_IDLE, PH_SYNC_PAUSE, PH_WR_DATA: ;
          PH_SYNC_WAIT: begin
            if (beat.rx_byte == ubfh_pkg::BL_ACK) begin
              txb[0] = ubfh_pkg::CMD_READ_ID; txb[1] = ~ubfh_pkg::CMD_READ_ID;
              ntx = 3'd2; wait_nxt = cmd_to_r; phase_nxt = PH_ID_CMD_ACK;
            end else begin
              wait_nxt = ubfh_pkg::SYNC_PAUSE; phase_nxt = PH_SYNC_PAUSE;
            end
          end
          PH_ID_COUNT: begin
            id_left_nxt = {1'b0, beat.rx_byte} + 9'd1;
            id_idx_nxt = '0; wait_nxt = cmd_to_r; phase_nxt = PH_ID_BYTES;
          end
          PH_ID_BYTES: begin
            if (id_idx_r == 2'd0) id_nxt = {beat.rx_byte, 8'd0};
            else if (id_idx_r == 2'd1) id_nxt = {id_r[15:8], beat.rx_byte};
            if (id_idx_r != 2'd2) id_idx_nxt = id_idx_r + 2'd1;
            id_left_nxt = id_left_r - 9'd1;
            wait_nxt = cmd_to_r;
            if (id_left_nxt == '0) phase_nxt = PH_ID_ACK;
          end
          default: begin
            if (beat.rx_byte != ubfh_pkg::BL_ACK) begin
              err_nxt = (beat.rx_byte == ubfh_pkg::BL_NACK) ?
                        ubfh_pkg::ERR_NACK : ubfh_pkg::ERR_UNEXP;
              phase_nxt = PH_IDLE;
            end else begin
              priority case (phase_r)
                PH_ID_CMD_ACK: begin
                  phase_nxt = PH_ID_COUNT; wait_nxt = cmd_to_r;
                end
                PH_ID_ACK: begin
                  chip_nxt = id_r; mism_nxt = (id_r != exp_id_r);
                  txb[0] = ubfh_pkg::CMD_ERASE; txb[1] = ~ubfh_pkg::CMD_ERASE;
                  ntx = 3'd2; wait_nxt = cmd_to_r; phase_nxt = PH_ERASE_CMD_ACK;
                end
                PH_ERASE_CMD_ACK: begin
                  txb[0] = 8'hFF; txb[1] = 8'hFF; txb[2] = 8'h00; ntx = 3'd3;
                  wait_nxt = erase_to_r; phase_nxt = PH_ERASE_ACK;
                end
                PH_ERASE_ACK: begin
                  txb[0] = ubfh_pkg::CMD_WRITE; txb[1] = ~ubfh_pkg::CMD_WRITE;
                  ntx = 3'd2; wait_nxt = cmd_to_r; phase_nxt = PH_WR_CMD_ACK;
                end
                PH_WR_CMD_ACK: begin
                  txb[0] = addr[31:24]; txb[1] = addr[23:16];
                  txb[2] = addr[15:8];  txb[3] = addr[7:0];
                  txb[4] = addr[31:24] ^ addr[23:16] ^ addr[15:8] ^ addr[7:0];
                  ntx = 3'd5; wait_nxt = cmd_to_r; phase_nxt = PH_WR_ADDR_ACK;
                end
                PH_WR_ADDR_ACK: begin
                  chunk_nxt = csz;
                  csum_nxt = 8'(csz - 1'b1);
                  txb[0] = csum_nxt; ntx = 3'd1;
                  byte_idx_nxt = '0; phase_nxt = PH_WR_DATA;
                end
                PH_WR_ACK: begin
                  offset_nxt = off_sum;
                  if (off_sum >= run_len_r) begin
                    done_nxt = 1'b1; phase_nxt = PH_IDLE;
                  end else begin
                    txb[0] = ubfh_pkg::CMD_WRITE; txb[1] = ~ubfh_pkg::CMD_WRITE;
                    ntx = 3'd2; wait_nxt = cmd_to_r; phase_nxt = PH_WR_CMD_ACK;
                  end
                end
                default: ;
              endcase
            end
          end
        endcase
      end
      ubfh_pkg::OP_TICK: begin
        if (phase_r != PH_IDLE && phase_r != PH_WR_DATA) begin
          if (wait_r > 14'd1) begin
            wait_nxt = wait_r - 14'd1;
          end else begin
            wait_nxt = '0;
            if (phase_r == PH_SYNC_WAIT) begin
              wait_nxt = ubfh_pkg::SYNC_PAUSE; phase_nxt = PH_SYNC_PAUSE;
            end else if (phase_r == PH_SYNC_PAUSE) begin
              retry_nxt = retry_inc;
              if (retry_inc >= sync_lim_r || retry_inc == '0) begin
                err_nxt = ubfh_pkg::ERR_SYNC; phase_nxt = PH_IDLE;
              end else begin
                txb[0] = ubfh_pkg::CMD_SYNC; ntx = 3'd1;
                wait_nxt = sync_to_r; phase_nxt = PH_SYNC_WAIT;
              end
            end else begin
              err_nxt = ubfh_pkg::ERR_TIMEOUT; phase_nxt = PH_IDLE;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_address_r <= 32'h0800_0000; image_length_r <= '0;
      sync_lim_r <= 14'd10000; sync_to_r <= 14'd200; cmd_to_r <= 14'd1000;
      erase_to_r <= 14'd10000; write_to_r <= 14'd2000; exp_id_r <= 16'd1129;
      phase_r <= PH_IDLE; id_idx_r <= '0; byte_idx_r <= '0; chunk_r <= '0;
      wait_r <= '0; retry_r <= '0; csum_r <= '0; offset_r <= '0;
      run_len_r <= '0; run_addr_r <= '0; id_r <= '0; chip_r <= '0;
      id_left_r <= '0; done_r <= 1'b0; mism_r <= 1'b0; err_r <= '0;
      sv_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          ubfh_pkg::REG_START_ADDR: start_address_r <= cfg_data;
          ubfh_pkg::REG_IMAGE_LEN:  image_length_r <= cfg_data[24:0];
          ubfh_pkg::REG_SYNC_LIM:   sync_lim_r <= cfg_data[13:0];
          ubfh_pkg::REG_SYNC_TO:    sync_to_r <= cfg_data[13:0];
          ubfh_pkg::REG_CMD_TO:     cmd_to_r <= cfg_data[13:0];
          ubfh_pkg::REG_ERASE_TO:   erase_to_r <= cfg_data[13:0];
          ubfh_pkg::REG_WRITE_TO:   write_to_r <= cfg_data[13:0];
          ubfh_pkg::REG_CHIP_ID:    exp_id_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      sv_r <= beat_valid;
      if (beat_valid) begin
        phase_r <= phase_nxt; id_idx_r <= id_idx_nxt; byte_idx_r <= byte_idx_nxt;
        chunk_r <= chunk_nxt; wait_r <= wait_nxt; retry_r <= retry_nxt;
        csum_r <= csum_nxt; offset_r <= offset_nxt; run_len_r <= run_len_nxt;
        run_addr_r <= run_addr_nxt; id_r <= id_nxt; chip_r <= chip_nxt;
        id_left_r <= id_left_nxt; done_r <= done_nxt; mism_r <= mism_nxt;
        err_r <= err_nxt;
        step_r.ntx         <= ntx;
        step_r.txb         <= txb;
        step_r.st.busy     <= (phase_nxt != PH_IDLE);
        step_r.st.done     <= done_nxt;
        step_r.st.err      <= err_nxt;
        step_r.st.chip_id  <= chip_nxt;
        step_r.st.mismatch <= mism_nxt;
        step_r.st.offset   <= offset_nxt;
        step_r.st.want     <= (phase_nxt == PH_WR_DATA);
      end
    end
  end

  assign step_valid = sv_r;
  assign step = step_r;

endmodule

// File: rtl/core/ubfh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubfh_queue: step record queue
// Small FIFO between the sequencer and the byte serializer.
// ----------------------------------------------------------------------------
module ubfh_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  ubfh_pkg::step_t wr_data,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic            rd_valid,
  input  logic            rd_en,
  output ubfh_pkg::step_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ubfh_pkg::step_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [$clog2(DEPTH+1)-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (wr_en ? 1'b1 : 1'b0) - (rd_en ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r] <= wr_data;
  end

  assign count = cnt_r;
  assign rd_valid = (cnt_r != '0);
  assign rd_data = mem[rp_r];

endmodule

// File: rtl/core/ubfh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubfh_back: result serializer
// Splits each step record into one result beat per byte to send, or one status beat.
// ----------------------------------------------------------------------------
module ubfh_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_valid,
  input  ubfh_pkg::step_t     step,
  output logic                step_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output ubfh_pkg::out_beat_t out_data
);

  logic [2:0] idx_r;
  logic       is_last;
  logic [2:0] n;

  assign n = (step.ntx == 3'd0) ? 3'd1 : step.ntx;
  assign is_last = (idx_r == n - 3'd1);
  assign out_valid = step_valid;
  assign step_pop = step_valid && out_ready && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (step_valid && out_ready) begin
      idx_r <= is_last ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_comb begin
    out_data.tx_valid        = (step.ntx != 3'd0);
    out_data.tx_byte         = (step.ntx != 3'd0) ? step.txb[idx_r] : 8'd0;
    out_data.last            = is_last;
    out_data.busy_res        = step.st.busy;
    out_data.done_res        = step.st.done;
    out_data.error_code      = step.st.err;
    out_data.chip_id         = step.st.chip_id;
    out_data.chip_mismatch   = step.st.mismatch;
    out_data.bytes_written   = step.st.offset;
    out_data.want_image_byte = step.st.want;
  end

endmodule

// File: rtl/core/uart_bootloader_flash_host.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_bootloader_flash_host: UART bootloader flashing host
// Takes one input beat per cycle while the step queue has room; each beat
// produces one to five result beats, one per byte sent to the target (or a
// single status beat). The result side drains one beat per cycle while
// out_ready is high, so the sustained rate is set by the result count per
// input: one result beat for a beat that sends at most one byte, five for
// an address beat. Input beats pass the sequencer register, then the queue.
// ----------------------------------------------------------------------------
module uart_bootloader_flash_host #(
  parameter int MAX_CHUNK = 256,
  parameter int QDEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  ubfh_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ubfh_pkg::out_beat_t out_data
);

  logic            fv, qv, pop;
  ubfh_pkg::step_t fs, qs;
  logic [$clog2(QDEPTH+2)-1:0] cnt;
  logic            acc;

  // one record may be in flight in the sequencer register
  assign in_ready = (32'(cnt) + (fv ? 32'd1 : 32'd0)) < QDEPTH;
  assign acc = in_valid && in_ready;

  ubfh_front #(.MAX_CHUNK(MAX_CHUNK)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .beat_valid(acc), .beat(in_data), .step_valid(fv), .step(fs)
  );

  ubfh_queue #(.DEPTH(QDEPTH + 1)) u_queue (
    .clk, .rst_n, .wr_en(fv), .wr_data(fs), .count(cnt),
    .rd_valid(qv), .rd_en(pop), .rd_data(qs)
  );

  ubfh_back u_back (
    .clk, .rst_n, .step_valid(qv), .step(qs), .step_pop(pop),
    .out_valid, .out_ready, .out_data
  );

endmodule

// File: rtl/core/ubfh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubfh_checker: port-level checks
// Checks input hold, result framing and status consistency seen at the ports.
// ----------------------------------------------------------------------------
module ubfh_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ubfh_pkg::out_beat_t out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input beat dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.tx_valid |-> out_data.last && out_data.tx_byte == 8'd0)
    else $error("status-only beat not framed alone");

  a_want_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.want_image_byte |-> out_data.busy_res)
    else $error("image byte wanted while idle");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done with run active");

endmodule

bind uart_bootloader_flash_host ubfh_checker u_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
